// File: rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg - shared types and constants
// Field widths, register indexes, reset values and the bit layout of the
// 3x3 local binary pattern.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int CCOL_W     = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;

    localparam int MIN_DIM      = 3;
    localparam int MAX_HEIGHT   = 4096;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // pattern bit positions, clockwise from top-left
    localparam int BIT_TL = 7;
    localparam int BIT_T  = 6;
    localparam int BIT_TR = 5;
    localparam int BIT_R  = 4;
    localparam int BIT_BR = 3;
    localparam int BIT_B  = 2;
    localparam int BIT_BL = 1;
    localparam int BIT_L  = 0;

    typedef logic [PIX_W-1:0] pix_t;

    // position tag carried alongside a pixel through the pipe
    typedef struct packed {
        logic              emit;
        logic              last;
        logic [ROW_W-1:0]  row_m1;
        logic [CCOL_W-1:0] col_m1;
    } pos_t;

    typedef struct packed {
        logic [PIX_W-1:0]  code;
        logic [ROW_W-1:0]  row;
        logic [CCOL_W-1:0] col;
        logic              last;
    } result_t;

endpackage

// File: rtl/lbp_ifs.sv
// ----------------------------------------------------------------------------
// lbp channel interfaces
// Pixel input, pattern output and register write channels.
// ----------------------------------------------------------------------------
interface lbp_pix_if;
    logic                  valid;
    logic                  ready;
    logic [lbp_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface lbp_code_if;
    logic                          valid;
    logic                          ready;
    logic [lbp_pkg::PIX_W-1:0]     lbp_code;
    logic [lbp_pkg::ROW_W-1:0]     center_row;
    logic [lbp_pkg::CCOL_W-1:0]    center_col;
    logic                          last_of_frame;

    modport source (output valid, output lbp_code, output center_row,
                    output center_col, output last_of_frame, input ready);
    modport sink   (input valid, input lbp_code, input center_row,
                    input center_col, input last_of_frame, output ready);
endinterface

interface lbp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lbp_pkg::CFG_IDX_W-1:0]     index;
    logic [lbp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lbp_pos_ctr.sv
// ----------------------------------------------------------------------------
// lbp_pos_ctr - frame geometry registers and raster position counters
// Holds the clamped width and height, walks row and column per pixel word.
// ----------------------------------------------------------------------------
module lbp_pos_ctr #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  lbp_pkg::cfg_reg_t         cfg_idx,
    input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                      step,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output lbp_pkg::pos_t             pos
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WRST = (lbp_pkg::WIDTH_RESET < MAX_WIDTH) ?
                          lbp_pkg::WIDTH_RESET : MAX_WIDTH;

    logic [CW-1:0]             wlast_reg;
    logic [CW-1:0]             wlast_next;
    logic [lbp_pkg::ROW_W-1:0] hlast_reg;
    logic [lbp_pkg::ROW_W-1:0] hlast_next;
    logic [CW-1:0]             col_reg;
    logic [CW-1:0]             col_next;
    logic [lbp_pkg::ROW_W-1:0] row_reg;
    logic [lbp_pkg::ROW_W-1:0] row_next;
    logic [lbp_pkg::IMG_W_W-1:0] wv;
    logic [lbp_pkg::IMG_H_W-1:0] hv;
    logic                      row_end;

    assign wv = cfg_data[lbp_pkg::IMG_W_W-1:0];
    assign hv = cfg_data[lbp_pkg::IMG_H_W-1:0];

    // saturate written geometry, keep it as last index
    always_comb
    begin
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                lbp_pkg::REG_IMAGE_WIDTH:
                begin
                    if (32'(wv) < lbp_pkg::MIN_DIM)
                        wlast_next = CW'(lbp_pkg::MIN_DIM - 1);
                    else if (32'(wv) > MAX_WIDTH)
                        wlast_next = CW'(MAX_WIDTH - 1);
                    else
                        wlast_next = CW'(wv - 1'b1);
                end
                lbp_pkg::REG_IMAGE_HEIGHT:
                begin
                    if (32'(hv) < lbp_pkg::MIN_DIM)
                        hlast_next = lbp_pkg::ROW_W'(lbp_pkg::MIN_DIM - 1);
                    else if (32'(hv) > lbp_pkg::MAX_HEIGHT)
                        hlast_next = lbp_pkg::ROW_W'(lbp_pkg::MAX_HEIGHT - 1);
                    else
                        hlast_next = lbp_pkg::ROW_W'(hv - 1'b1);
                end
                default:
                begin
                    wlast_next = wlast_reg;
                end
            endcase
        end
    end

    assign row_end = (col_reg == wlast_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (step)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = (row_reg == hlast_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= CW'(WRST - 1);
            hlast_reg <= lbp_pkg::ROW_W'(lbp_pkg::HEIGHT_RESET - 1);
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            wlast_reg <= wlast_next;
            hlast_reg <= hlast_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    assign col        = col_reg;
    assign pos.emit   = (row_reg >= lbp_pkg::ROW_W'(2)) && (col_reg >= CW'(2));
    assign pos.last   = row_end && (row_reg == hlast_reg);
    assign pos.row_m1 = row_reg - 1'b1;
    assign pos.col_m1 = lbp_pkg::CCOL_W'(col_reg - 1'b1);

endmodule

// File: rtl/lbp_line_buf.sv
// ----------------------------------------------------------------------------
// lbp_line_buf - two line stores
// Older and newer rows; registered read at accept, write-back as the word leaves stage 1.
// ----------------------------------------------------------------------------
module lbp_line_buf #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  lbp_pkg::pix_t            wr_pix,
    output lbp_pkg::pix_t            top,
    output lbp_pkg::pix_t            mid
);

    lbp_pkg::pix_t older_mem [DEPTH];
    lbp_pkg::pix_t newer_mem [DEPTH];
    lbp_pkg::pix_t top_reg;
    lbp_pkg::pix_t mid_reg;

    // the newer row moves down into the older row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= mid_reg;
            newer_mem[wr_addr] <= wr_pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            top_reg <= older_mem[rd_addr];
            mid_reg <= newer_mem[rd_addr];
        end
    end

    assign top = top_reg;
    assign mid = mid_reg;

endmodule

// File: rtl/lbp_window.sv
// ----------------------------------------------------------------------------
// lbp_window - 3x3 window, comparators and result register
// Shifts in one column per word and registers the pattern for interior pixels.
// ----------------------------------------------------------------------------
module lbp_window (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  lbp_pkg::pix_t     top,
    input  lbp_pkg::pix_t     mid,
    input  lbp_pkg::pix_t     bot,
    input  lbp_pkg::pos_t     pos,
    input  logic              out_ready,
    output logic              out_valid,
    output lbp_pkg::result_t  result
);

    // [0..2] two columns back, [3..5] one column back; top, middle, bottom
    lbp_pkg::pix_t    win_reg [6];
    lbp_pkg::pix_t    ctr;
    lbp_pkg::pix_t    code;
    logic             out_valid_reg;
    logic             out_valid_next;
    lbp_pkg::result_t res_reg;

    assign ctr = win_reg[4];

    always_comb
    begin
        code                 = '0;
        code[lbp_pkg::BIT_TL] = (win_reg[0] >= ctr);
        code[lbp_pkg::BIT_T]  = (win_reg[3] >= ctr);
        code[lbp_pkg::BIT_TR] = (top >= ctr);
        code[lbp_pkg::BIT_R]  = (mid >= ctr);
        code[lbp_pkg::BIT_BR] = (bot >= ctr);
        code[lbp_pkg::BIT_B]  = (win_reg[5] >= ctr);
        code[lbp_pkg::BIT_BL] = (win_reg[2] >= ctr);
        code[lbp_pkg::BIT_L]  = (win_reg[1] >= ctr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= bot;
        end
    end

    always_comb
    begin
        priority if (advance && pos.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && pos.emit)
        begin
            res_reg.code <= code;
            res_reg.row  <= pos.row_m1;
            res_reg.col  <= pos.col_m1;
            res_reg.last <= pos.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

// File: rtl/lbp_3x3_pixel_stream.sv
// ----------------------------------------------------------------------------
// lbp_3x3_pixel_stream - 8-neighbour local binary pattern over a pixel stream
// Two line stores and a 3x3 window; one code per interior pixel, flagged on
// the last one of each frame.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake        word contents
//  --------  ----  ---------------  ------------------------------------------
//  pix_in    in    valid / ready    pixel (8b grey, raster order)
//  lbp_out   out   valid / ready    lbp_code, center_row, center_col,
//                                   last_of_frame
//  cfg       in    valid / ready    index (0 width, 1 height), data (13b)
//
//  One pixel word per clock sustained while lbp_out takes codes; a word
//  passes the line store read, then the compare into the result register.
//  Stage 1 holds the accepted pixel while the line store read completes;
//  it drains whenever the result register is empty or being taken, so a
//  stalled output holds at most one word in each stage.
//  Reset clears counters, window and valid flags; line stores hold rubbish
//  until the first two rows of a frame have passed. cfg is always ready and
//  a write restarts the frame at row 0, column 0.
//
module lbp_3x3_pixel_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    lbp_cfg_if.sink      cfg,
    lbp_pix_if.sink      pix_in,
    lbp_code_if.source   lbp_out
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic              cfg_we;
    logic              pix_acc;
    logic [CW-1:0]     col;
    lbp_pkg::pos_t     pos;

    // stage 1: pixel word waiting on its line store read
    logic              s1_valid_reg;
    logic              s1_valid_next;
    lbp_pkg::pix_t     s1_pix_reg;
    logic [CW-1:0]     s1_col_reg;
    lbp_pkg::pos_t     s1_pos_reg;
    logic              s1_go;

    lbp_pkg::pix_t     top;
    lbp_pkg::pix_t     mid;
    logic              out_valid;
    lbp_pkg::result_t  result;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    // stage 1 moves on when the result slot is free or being emptied
    assign s1_go        = s1_valid_reg && (!out_valid || lbp_out.ready);
    assign pix_in.ready = !s1_valid_reg || s1_go;
    assign pix_acc      = pix_in.valid && pix_in.ready;

    lbp_pos_ctr #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (lbp_pkg::cfg_reg_t'(cfg.index)),
        .cfg_data (cfg.data),
        .step     (pix_acc),
        .col      (col),
        .pos      (pos)
    );

    always_comb
    begin
        priority if (pix_acc)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_pix_reg <= pix_in.pixel;
            s1_col_reg <= col;
            s1_pos_reg <= pos;
        end
    end

    // read at accept, write back as the word leaves stage 1; consecutive
    // words within a frame sit in different columns so the two never collide
    lbp_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .rd_en   (pix_acc),
        .rd_addr (col),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_pix  (s1_pix_reg),
        .top     (top),
        .mid     (mid)
    );

    lbp_window u_win (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_go),
        .top       (top),
        .mid       (mid),
        .bot       (s1_pix_reg),
        .pos       (s1_pos_reg),
        .out_ready (lbp_out.ready),
        .out_valid (out_valid),
        .result    (result)
    );

    assign lbp_out.valid         = out_valid;
    assign lbp_out.lbp_code      = result.code;
    assign lbp_out.center_row    = result.row;
    assign lbp_out.center_col    = result.col;
    assign lbp_out.last_of_frame = result.last;

    // ---- assertions ----

    // an interior word leaving stage 1 lands in the result register
    a_emit_reaches_out : assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_go && s1_pos_reg.emit |=> lbp_out.valid
    ) else $error("interior word lost between stage 1 and output");

    // never overwrite a word still waiting in stage 1
    a_no_s1_overrun : assert property (
        @(posedge clk) disable iff (!rst_n)
        pix_acc |-> (!s1_valid_reg || s1_go)
    ) else $error("stage 1 overrun");

    // centre rows start at one
    a_row_nonzero : assert property (
        @(posedge clk) disable iff (!rst_n)
        lbp_out.valid |-> (lbp_out.center_row != '0)
    ) else $error("code emitted for a border row");

endmodule
